@@ rtl/glg_pkg.sv @@
// Package for grid_link_graph_table: request/response types, mode and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package glg_pkg;
  localparam int unsigned MODE_ADD  = 3'd0;
  localparam int unsigned MODE_REM  = 3'd1;
  localparam int unsigned MODE_CON  = 3'd2;
  localparam int unsigned MODE_DIS  = 3'd3;
  localparam int unsigned MODE_QRY  = 3'd4;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_IGN  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       connected;
    logic [8:0] vertex_total;
  } rsp_t;
endpackage
`default_nettype wire

@@ rtl/glg_search.sv @@
// Coordinate search for grid_link_graph_table: sequential scan of the coordinate memory.
// Depends on glg_pkg; owns the coordinate memory (one write, one read port).
`timescale 1ns / 1ps
`default_nettype none
module glg_search import glg_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_BITS = 16,
  localparam int unsigned AW = $clog2(MAX_VERTICES),
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [2*COORD_BITS-1:0] key,
  input  wire logic [CW-1:0]           count,
  output logic                         done,
  output logic                         found,
  output logic [AW-1:0]                slot,
  input  wire logic [AW-1:0]           rd_addr,
  output logic [2*COORD_BITS-1:0]      rd_data,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [2*COORD_BITS-1:0] wr_data
);
  logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
  logic                    busy, chk;
  logic [CW-1:0]           idx;
  logic [AW-1:0]           chk_slot;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[busy ? idx[AW-1:0] : rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk <= 1'b0;
      done <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        chk <= 1'b0;
        idx <= '0;
        found <= 1'b0;
      end else if (busy) begin
        chk <= 1'b0;
        if (chk && rd_data == key) begin
          busy <= 1'b0;
          done <= 1'b1;
          found <= 1'b1;
          slot <= chk_slot;
        end else if (idx >= count) begin
          if (!chk) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          chk <= 1'b1;
          chk_slot <= idx[AW-1:0];
          idx <= idx + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/grid_link_graph_table.sv @@
// grid_link_graph_table
// Channels: req (valid/ready, req_t) and rsp (valid/ready, rsp_t), one response
// per request. Coordinates are wrapped to COORD_BITS. Requests are handled one
// at a time: each does one or two sequential coordinate searches (one
// coordinate memory read per cycle), then a sequence of link-memory
// read/modify/write steps, one read or write per cycle. A remove makes two
// passes over the four links plus the copy of the last slot.
// Ready is high only while idle; it returns after a response is registered,
// by way of the wait state.
// The response sits in an output register, so the next request is worked while
// it waits; a stalled receiver then holds that next response in the block and
// ready stays low. Reset clears the vertex count and control state only;
// memories are not cleared (an added vertex writes all its links before any
// read). Ready rises as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module grid_link_graph_table import glg_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned KW = 2 * COORD_BITS;
  localparam int unsigned LW = AW + 1;
  // internal write phases of disconnect and connect
  localparam logic [2:0] MODE_DIS_WR = 3'd5;
  localparam logic [2:0] MODE_CON_WR = 3'd6;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001, S_SA  = 12'b000000000010,
    S_SB   = 12'b000000000100, S_DEC = 12'b000000001000,
    S_RD   = 12'b000000010000, S_RW  = 12'b000000100000,
    S_CPC  = 12'b000001000000, S_CPW = 12'b000010000000,
    S_NB   = 12'b000100000000, S_NBW = 12'b001000000000,
    S_RSP  = 12'b010000000000, S_WAIT = 12'b100000000000
  } state_t;

  state_t state;
  req_t   r;
  logic [CW-1:0] count;
  logic [AW-1:0] sa, sb, last;
  logic [1:0]    d1;
  logic [LW-1:0] la [4];       // links of first vertex (or last in copy)
  logic [LW-1:0] lb;
  logic [3:0]    step;
  logic [1:0]    phase;        // remove: 0 clear nbrs,1 copy,2 repoint
  rsp_t          out;

  function automatic logic [COORD_BITS-1:0] nc(input logic [15:0] v);
    logic [31:0] e;
    e = {{16{v[15]}}, v};
    return e[COORD_BITS-1:0];
  endfunction

  wire [COORD_BITS-1:0] ax = nc(r.first_x), ay = nc(r.first_y);
  wire [COORD_BITS-1:0] bx = nc(r.second_x), by = nc(r.second_y);

  // search unit
  logic s_start, s_done, s_found;
  logic [KW-1:0] s_key, c_rd, c_wd;
  logic [AW-1:0] s_slot, c_ra, c_wa;
  logic c_we;
  glg_search #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_srch (
    .clk, .rst, .start(s_start), .key(s_key), .count(count), .done(s_done),
    .found(s_found), .slot(s_slot), .rd_addr(c_ra), .rd_data(c_rd),
    .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd));

  // link memory
  logic [LW-1:0] lmem [MAX_VERTICES*4];
  logic [AW+1:0] l_ra, l_wa;
  logic [LW-1:0] l_rd, l_wd;
  logic          l_we;
  always_ff @(posedge clk) begin
    if (l_we) lmem[l_wa] <= l_wd;
    l_rd <= lmem[l_ra];
  end

  wire signed [COORD_BITS-1:0] sax = ax, say = ay, sbx = bx, sby = by;
  wire [1:0] dir = (ax == bx) ? ((sby > say) ? 2'd0 : 2'd2) : ((sbx > sax) ? 2'd1 : 2'd3);
  wire pair_ok = ((ax == bx) || (ay == by)) && !((ax == bx) && (ay == by));
  wire fwd = la[0][AW] && la[0][AW-1:0] == sb;

  // sequencer step descriptors
  logic [AW-1:0] tgt;
  logic [1:0] sd, step_d;
  assign step_d = step[1:0];

  always_comb begin
    s_start = 1'b0;
    s_key = {ax, ay};
    c_ra = last;
    c_we = 1'b0; c_wa = count[AW-1:0]; c_wd = {ax, ay};
    l_ra = {sa, d1};
    tgt = la[step_d][AW-1:0];
    sd = step_d + 2'd2;
    case (state)
      S_IDLE: s_start = req_valid;
      S_SA: if (s_done && r.mode >= 3'(MODE_CON) && r.mode <= 3'(MODE_QRY) && s_found)
              begin s_start = 1'b1; s_key = {bx, by}; end
      S_SB: s_key = {bx, by};
      S_RD: l_ra = (r.mode == 3'(MODE_REM)) ? {(phase == 2'd1 ? last : sa), step_d}
                   : (step == 4'd0 ? {sa, d1} : {sb, d1 + 2'd2});
      S_NBW: c_we = (phase == 2'd3);
      S_CPW: begin
        c_we = 1'b1; c_wa = sa; c_wd = c_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: if (req_valid) begin
          r <= req; state <= S_SA;
          last <= AW'(count - 1'b1);
        end
        S_SA: if (s_done) begin
          sa <= s_slot;
          out <= '{status: ST_IGN, connected: 1'b0, vertex_total: 9'(count)};
          if (r.mode == 3'(MODE_ADD)) begin
            if (s_found) state <= S_RSP;
            else if (count >= CW'(MAX_VERTICES)) begin
              out.status <= ST_FULL; state <= S_RSP;
            end else begin
              step <= '0; state <= S_NBW; phase <= 2'd3;
            end
          end else if (r.mode == 3'(MODE_REM)) begin
            if (s_found) begin step <= '0; phase <= 2'd0; state <= S_RD; end
            else state <= S_RSP;
          end else if (r.mode >= 3'(MODE_CON) && r.mode <= 3'(MODE_QRY)) begin
            state <= (s_found) ? S_SB : S_RSP;
          end else state <= S_RSP;
        end
        S_SB: if (s_done) begin
          sb <= s_slot; d1 <= dir; step <= '0;
          if (s_found && pair_ok) state <= S_RD;
          else state <= S_RSP;
        end
        S_RD: state <= S_DEC;
        S_DEC: begin
          if (r.mode == 3'(MODE_REM)) begin
            la[step_d] <= l_rd;
            if (step_d == 2'd3) begin
              step <= '0; state <= S_NB;
              if (phase == 2'd1) phase <= 2'd2;
            end else begin step <= step + 1'b1; state <= S_RD; end
          end else if (step == 4'd0) begin
            la[0] <= l_rd; step <= 4'd1; state <= S_RD;
          end else begin
            lb <= l_rd; step <= '0; state <= S_RW;
          end
        end
        S_RW: begin
          // connect / disconnect / query: query answers, the others write step-wise
          state <= S_RSP;
          if (r.mode == 3'(MODE_QRY)) begin
            out.status <= ST_DONE;
            out.connected <= fwd;
          end else if (r.mode == 3'(MODE_DIS)) begin
            if (fwd) begin
              state <= S_RW;
              r.mode <= MODE_DIS_WR;
            end
          end else if (r.mode == 3'(MODE_CON)) begin
            state <= S_RW; r.mode <= MODE_CON_WR;
          end else if (r.mode == MODE_DIS_WR) begin
            if (step == 4'd0) begin step <= 4'd1; state <= S_RW; end
            else out.status <= ST_DONE;
          end else begin
            if (step == 4'd3) out.status <= ST_DONE;
            else state <= S_RW;
            step <= step + 1'b1;
          end
        end
        S_NB: begin
          // remove sequencer: for each direction with a link, write neighbour
          if (la[step_d][AW]) begin
            state <= S_NBW;
          end else if (step_d == 2'd3) begin
            state <= S_NBW;
            step <= 4'd8;
          end else step <= step + 1'b1;
        end
        S_NBW: begin
          if (phase == 2'd3) begin
            if (step == 4'd3) begin
              count <= count + 1'b1; out.status <= ST_DONE;
              out.vertex_total <= 9'(count + 1'b1); state <= S_RSP;
            end else step <= step + 1'b1;
          end else if (step == 4'd8 || step_d == 2'd3) begin
            if (phase == 2'd0 && sa != last) begin
              phase <= 2'd1; step <= '0; state <= S_CPC;
            end else begin
              count <= count - 1'b1; out.status <= ST_DONE;
              out.vertex_total <= 9'(count - 1'b1); state <= S_RSP;
            end
          end else begin
            step <= step + 1'b1; state <= S_NB;
          end
        end
        S_CPC: state <= S_CPW;
        S_CPW: begin step <= '0; state <= S_RD; end
        S_RSP: if (!rsp_valid || rsp_ready) begin
          rsp_valid <= 1'b1; rsp <= out; state <= S_WAIT;
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // link memory write port
  always_comb begin
    l_we = 1'b0; l_wa = {sa, d1}; l_wd = '0;
    if (state == S_RW && r.mode == MODE_DIS_WR) begin
      l_we = 1'b1;
      l_wa = (step == 4'd0) ? {sa, d1} : {sb, d1 + 2'd2};
    end else if (state == S_RW && r.mode == MODE_CON_WR) begin
      case (step)
        4'd0: begin l_we = la[0][AW]; l_wa = {la[0][AW-1:0], d1 + 2'd2}; end
        4'd1: begin l_we = lb[AW]; l_wa = {lb[AW-1:0], d1}; end
        4'd2: begin l_we = 1'b1; l_wa = {sa, d1}; l_wd = {1'b1, sb}; end
        default: begin l_we = 1'b1; l_wa = {sb, d1 + 2'd2}; l_wd = {1'b1, sa}; end
      endcase
    end else if (state == S_DEC && r.mode == 3'(MODE_REM) && phase == 2'd1) begin
      // copy of the last slot's links into the freed slot
      l_we = 1'b1; l_wa = {sa, step_d}; l_wd = l_rd;
    end else if (state == S_NBW && phase == 2'd3) begin
      l_we = 1'b1; l_wa = {count[AW-1:0], step_d};
    end else if (state == S_NBW && step != 4'd8 && la[step_d][AW]) begin
      l_we = 1'b1; l_wa = {tgt, sd};
      if (phase == 2'd2) l_wd = {1'b1, sa};
    end
  end

  assign req_ready = (state == S_IDLE) && !rst;
endmodule
`default_nettype wire
